// File: design/aes_pkg.sv
// aes_pkg: types, tables and round functions for the aes-128 block cipher
// no dependencies; used by every module of the block
package aes_pkg;

  localparam int NumRoundsDefault = 10;
  localparam int KeyRegs = 2;

  typedef struct packed {
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef enum logic [0:0] {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } aes_func_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } aes_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } aes_state_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_RUN
  } aes_ks_state_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a 128-bit word, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int k);
    get_byte = w[127 - 8*k -: 8];
  endfunction

  // subbytes then shiftrows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(c*4 + r) -: 8] = FWD_BOX[get_byte(s, ((c + r) % 4)*4 + r)];
      end
    end
    sub_shift = o;
  endfunction

  // inverse shiftrows then inverse subbytes
  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(((c + r) % 4)*4 + r) -: 8] = INV_BOX[get_byte(s, c*4 + r)];
      end
    end
    inv_sub_shift = o;
  endfunction

  // forward mixcolumns
  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4 + 1);
      a2 = get_byte(s, c*4 + 2);
      a3 = get_byte(s, c*4 + 3);
      o[127 - 8*(c*4)     -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[127 - 8*(c*4 + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      o[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      o[127 - 8*(c*4 + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    mix_fwd = o;
  endfunction

  // inverse mixcolumns: premultiply by (05,00,04,00) then forward mix
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] p;
    logic [7:0] a0, a1, a2, a3, u, v;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4 + 1);
      a2 = get_byte(s, c*4 + 2);
      a3 = get_byte(s, c*4 + 3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      p[127 - 8*(c*4)     -: 8] = a0 ^ u;
      p[127 - 8*(c*4 + 1) -: 8] = a1 ^ v;
      p[127 - 8*(c*4 + 2) -: 8] = a2 ^ u;
      p[127 - 8*(c*4 + 3) -: 8] = a3 ^ v;
    end
    mix_inv = mix_fwd(p);
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// File: design/aes_key_sched.sv
// aes_key_sched: round key memory and the expansion sequencer that fills it
// depends on aes_pkg
module aes_key_sched #(
  parameter int NUM_ROUNDS = aes_pkg::NumRoundsDefault,
  parameter int AW = $clog2(NUM_ROUNDS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [127:0]  key,
  input  logic [AW-1:0] rd_addr,
  output logic [127:0]  rd_data,
  output logic          busy
);
  import aes_pkg::*;

  logic [127:0]  mem [NUM_ROUNDS + 1];
  aes_ks_state_t state, state_next;
  logic [AW-1:0] idx;
  logic [127:0]  cur;
  logic [7:0]    rc;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state == KS_RUN) begin
      mem[idx] <= cur;
    end
    rd_data <= mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_RUN;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      KS_IDLE: if (start) state_next = KS_RUN;
      KS_RUN: begin
        if (idx == AW'(NUM_ROUNDS) && !start) state_next = KS_IDLE;
      end
      default: state_next = KS_IDLE;
    endcase
  end

  // expansion registers: one round key per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cur <= '0;
      rc  <= 8'h01;
    end else if (start) begin
      idx <= '0;
      cur <= key;
      rc  <= 8'h01;
    end else if (state == KS_RUN) begin
      idx <= idx + 1'b1;
      cur <= next_key(cur, rc);
      rc  <= xt(rc);
    end
  end

  assign busy = (state == KS_RUN) || start;

endmodule

// File: design/aes_round.sv
// aes_round: iterative round datapath, one round per cycle from the key memory
// depends on aes_pkg
module aes_round #(
  parameter int NUM_ROUNDS = aes_pkg::NumRoundsDefault,
  parameter int AW = $clog2(NUM_ROUNDS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  aes_pkg::aes_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output aes_pkg::aes_out_t out_data,
  input  logic              key_busy,
  output logic [AW-1:0]     key_addr,
  input  logic [127:0]      key_data
);
  import aes_pkg::*;

  aes_state_t    state, state_next;
  logic [127:0]  st;
  logic          dec;
  logic [AW-1:0] rnd;
  logic          first;
  logic [127:0]  rnd_out;
  logic          take;

  assign take = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || key_busy;

  // key read address: the key used by the next cycle's round
  always_comb begin
    if (state == ST_IDLE) begin
      key_addr = (in_data.func == FUNC_DEC) ? AW'(NUM_ROUNDS) : '0;
    end else begin
      key_addr = dec ? (AW'(NUM_ROUNDS) - rnd - (first ? AW'(1) : AW'(2)))
                     : (rnd + (first ? AW'(1) : AW'(2)));
    end
  end

  // one round; rnd counts rounds finished after the initial key addition
  always_comb begin
    if (first) begin
      rnd_out = st ^ key_data;
    end else if (!dec) begin
      if (rnd == AW'(NUM_ROUNDS - 1)) rnd_out = sub_shift(st) ^ key_data;
      else rnd_out = mix_fwd(sub_shift(st)) ^ key_data;
    end else begin
      if (rnd == AW'(NUM_ROUNDS - 1)) rnd_out = inv_sub_shift(st) ^ key_data;
      else rnd_out = mix_inv(inv_sub_shift(st) ^ key_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = ST_RUN;
      ST_RUN:  if (!first && rnd == AW'(NUM_ROUNDS - 1)) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      st    <= {in_data.block_high, in_data.block_low};
      dec   <= in_data.func;
      rnd   <= '0;
      first <= 1'b1;
    end else if (state == ST_RUN) begin
      st    <= rnd_out;
      first <= 1'b0;
      if (!first) rnd <= rnd + 1'b1;
    end
  end

  assign out_valid = (state == ST_DONE);
  assign out_data.result_high = st[127:64];
  assign out_data.result_low  = st[63:0];

endmodule

// File: design/aes128_block_cipher_top.sv
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_data (func, block_high, block_low)
// out      | out_valid | out_stall | out_data (result_high, result_low)
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// an item runs from accept to result valid through the initial key add
// and ten rounds, one per cycle, each reading one round key from the memory.
// one item is in flight at a time; the next is taken after its result leaves.
// after reset the schedule fills the 11-entry round key memory;
// a key write holds in_stall high through the write, the start and the refill.
// reset is synchronous, active high.
//
// aes128_block_cipher_top: key registers and the two datapath parts
// depends on aes_pkg, aes_key_sched, aes_round
module aes128_block_cipher_top #(
  parameter int NUM_ROUNDS = aes_pkg::NumRoundsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  aes_pkg::aes_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output aes_pkg::aes_out_t out_data
);
  import aes_pkg::*;

  localparam int AW = $clog2(NUM_ROUNDS + 1);

  logic [63:0]   key_high;
  logic [63:0]   key_low;
  logic          key_busy;
  logic [AW-1:0] key_addr;
  logic [127:0]  key_data;
  logic          start;

  // key registers; any write restarts the schedule
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      start    <= 1'b0;
    end else begin
      start <= cfg_we;
      if (cfg_we && cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      if (cfg_we && cfg_index == REG_KEY_LOW)  key_low  <= cfg_data;
    end
  end

  aes_key_sched #(.NUM_ROUNDS(NUM_ROUNDS), .AW(AW)) u_sched (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .key     ({key_high, key_low}),
    .rd_addr (key_addr),
    .rd_data (key_data),
    .busy    (key_busy)
  );

  aes_round #(.NUM_ROUNDS(NUM_ROUNDS), .AW(AW)) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .key_busy  (key_busy || cfg_we),
    .key_addr  (key_addr),
    .key_data  (key_data)
  );

endmodule
